@@ rtl/sfrt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the swap frame replacement table.
// No dependencies; used by sfrt_core and the top level.
package sfrt_pkg;

  // Fixed field widths of one request and of one table entry
  localparam int SPACE_W     = 4;
  localparam int PAGE_W      = 5;
  localparam int ENTRY_W     = SPACE_W + PAGE_W;
  localparam int IN_TDATA_W  = 16;

  // Page index recorded for the stack page
  localparam logic [PAGE_W-1:0] STACK_PAGE = 5'd31;

  // Request kinds carried on in_tuser
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // One accepted request
  typedef struct packed {
    logic              opcode;
    logic [SPACE_W-1:0] space_id;
    logic              is_stack_page;
    logic [PAGE_W-1:0] page_number;
  } sfrt_req_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_SCAN,
    ST_REL_DONE
  } sfrt_state_t;

endpackage

@@ rtl/sfrt_pick.sv @@
`timescale 1ns / 1ps
// Victim selection: first free frame at or after the start frame, circularly.
// Falls back to the start frame when every frame is in use. No package use.
module sfrt_pick #(
  parameter int FRAME_COUNT = 16,
  localparam int IDX_W = $clog2(FRAME_COUNT)
) (
  input  logic [FRAME_COUNT-1:0] used,
  input  logic [IDX_W-1:0]       start,
  output logic [IDX_W-1:0]       pick_idx
);

  logic [FRAME_COUNT-1:0] free_vec;
  logic [FRAME_COUNT-1:0] upper_free;
  logic [IDX_W-1:0]       first_upper;
  logic [IDX_W-1:0]       first_any;

  // Split free frames into those at or above the start and all of them
  always_comb begin
    free_vec = ~used;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      upper_free[i] = free_vec[i] && (IDX_W'(i) >= start);
    end
  end

  // Lowest set bit of each vector
  always_comb begin
    first_upper = '0;
    first_any   = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (upper_free[i]) begin
        first_upper = IDX_W'(i);
      end
      if (free_vec[i]) begin
        first_any = IDX_W'(i);
      end
    end
  end

  // Prefer the upper part, then wrap around, else take the start frame
  always_comb begin
    priority if (|upper_free) begin
      pick_idx = first_upper;
    end else if (|free_vec) begin
      pick_idx = first_any;
    end else begin
      pick_idx = start;
    end
  end

endmodule

@@ rtl/sfrt_core.sv @@
`timescale 1ns / 1ps
// Frame table sequencer: valid bits, owner/page memory, rotating pointer.
// Depends on sfrt_pkg and sfrt_pick.
module sfrt_core #(
  parameter int FRAME_COUNT = 16,
  parameter int FRAME_BYTES = 4096,
  parameter int OUT_W       = 56
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [31:0]         pool_base,
  input  logic                req_valid,
  output logic                req_ready,
  input  sfrt_pkg::sfrt_req_t req,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [OUT_W-1:0]    res_data
);

  localparam int IDX_W = $clog2(FRAME_COUNT);
  localparam int CNT_W = $clog2(FRAME_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(FRAME_COUNT - 1);
  localparam logic [31:0]      FRAME_BYTES_W = 32'(FRAME_BYTES);

  sfrt_pkg::sfrt_state_t state_r, state_nxt;
  sfrt_pkg::sfrt_req_t   req_r;

  logic [IDX_W-1:0]       ptr_r;
  logic [IDX_W-1:0]       ptr_adv;
  logic [IDX_W-1:0]       pick_idx;
  logic [FRAME_COUNT-1:0] used_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   was_used_r;
  logic [CNT_W-1:0]       cnt_r;

  // Owner/page store, one synchronous read port and one write port
  logic [sfrt_pkg::ENTRY_W-1:0] mem [FRAME_COUNT];
  logic [sfrt_pkg::ENTRY_W-1:0] rdata_r;
  logic [sfrt_pkg::ENTRY_W-1:0] wdata;
  logic [sfrt_pkg::SPACE_W-1:0] rd_owner;
  logic [sfrt_pkg::PAGE_W-1:0]  rd_page;

  logic             accept;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic             scan_hit;
  logic [31:0]      frame_addr;

  assign accept   = req_valid && req_ready;
  assign ptr_adv  = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
  assign rd_owner = rdata_r[sfrt_pkg::ENTRY_W-1:sfrt_pkg::PAGE_W];
  assign rd_page  = rdata_r[sfrt_pkg::PAGE_W-1:0];
  assign wdata    = {req_r.space_id,
                     req_r.is_stack_page ? sfrt_pkg::STACK_PAGE : req_r.page_number};

  // Choose the frame for the advanced pointer
  sfrt_pick #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_pick (
    .used    (used_r),
    .start   (ptr_adv),
    .pick_idx(pick_idx)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfrt_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_nxt = (req.opcode == sfrt_pkg::OP_RELEASE) ? sfrt_pkg::ST_SCAN
                                                           : sfrt_pkg::ST_ALLOC;
        end
      end
      sfrt_pkg::ST_ALLOC: begin
        if (res_ready) begin
          state_nxt = sfrt_pkg::ST_IDLE;
        end
      end
      sfrt_pkg::ST_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = sfrt_pkg::ST_REL_DONE;
        end
      end
      sfrt_pkg::ST_REL_DONE: begin
        if (res_ready) begin
          state_nxt = sfrt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sfrt_pkg::ST_IDLE;
    endcase
  end

  // Control outputs per state
  always_comb begin
    req_ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    res_valid = 1'b0;
    scan_hit  = 1'b0;
    unique case (state_r)
      sfrt_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          rd_en   = 1'b1;
          rd_addr = (req.opcode == sfrt_pkg::OP_RELEASE) ? '0 : pick_idx;
        end
      end
      sfrt_pkg::ST_ALLOC: begin
        res_valid = 1'b1;
        wr_en     = res_ready;
      end
      sfrt_pkg::ST_SCAN: begin
        scan_hit = used_r[idx_r] && (rd_owner == req_r.space_id);
        if (idx_r != LAST_IDX) begin
          rd_en   = 1'b1;
          rd_addr = idx_r + 1'b1;
        end
      end
      sfrt_pkg::ST_REL_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // Result fields, packed from the lowest bit up
  assign frame_addr = pool_base + 32'(32'(idx_r) * FRAME_BYTES_W);

  always_comb begin
    if (state_r == sfrt_pkg::ST_ALLOC) begin
      res_data = OUT_W'({CNT_W'(0),
                         was_used_r ? rd_page  : '0,
                         was_used_r ? rd_owner : '0,
                         was_used_r,
                         frame_addr,
                         idx_r});
    end else begin
      res_data = OUT_W'({cnt_r, {(IDX_W + 42){1'b0}}});
    end
  end

  // Control state: sequencer, pointer, valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfrt_pkg::ST_IDLE;
      ptr_r   <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && (req.opcode == sfrt_pkg::OP_ALLOC)) begin
        ptr_r <= ptr_adv;
      end
      if (wr_en) begin
        used_r[idx_r] <= 1'b1;
      end
      if (scan_hit) begin
        used_r[idx_r] <= 1'b0;
      end
    end
  end

  // Hold the request, the chosen frame and the release count
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req;
      cnt_r <= '0;
      if (req.opcode == sfrt_pkg::OP_ALLOC) begin
        idx_r      <= pick_idx;
        was_used_r <= used_r[pick_idx];
      end else begin
        idx_r <= '0;
      end
    end else if (state_r == sfrt_pkg::ST_SCAN) begin
      idx_r <= idx_r + 1'b1;
      if (scan_hit) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Entry memory: write the new owner, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/swap_frame_replacement_table.sv @@
`timescale 1ns / 1ps
// Top level of the swap frame replacement table: ports, pool base register,
// output register. Depends on sfrt_pkg and sfrt_core.
//
//   channel  direction  handshake            payload
//   in_      slave      in_tvalid/in_tready  in_tdata, in_tuser (request kind)
//   out_     master     out_tvalid/out_tready out_tdata (result)
//   cfg_     slave      cfg_valid/cfg_ready  cfg_data (pool_base)
//
// Allocate picks the frame and reads its entry, then writes back once the result is taken.
// Release scans the table in ST_SCAN with one entry memory read per frame.
// One request is in the table at a time; the next is taken once its result
// moves to the output register, which may still wait on out_tready.
// Reset frees every frame at once through per-frame valid bits.
module swap_frame_replacement_table #(
  parameter int FRAME_COUNT = 16,
  parameter int FRAME_BYTES = 4096,
  localparam int IDX_W   = $clog2(FRAME_COUNT),
  localparam int CNT_W   = $clog2(FRAME_COUNT + 1),
  localparam int OUT_RAW = IDX_W + 42 + CNT_W,
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // space_id[3:0], is_stack_page[4], page_number[9:5], zero fill
  input  logic [sfrt_pkg::IN_TDATA_W-1:0] in_tdata,
  // opcode
  input  logic                            in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // frame_index, frame_address (32), evicted, evicted_space (4),
  // evicted_page (5), freed_count, zero fill
  output logic [OUT_W-1:0]                out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [31:0]                     cfg_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready
);

  localparam int EV_BIT   = IDX_W + 32;
  localparam int FREED_LO = IDX_W + 42;

  sfrt_pkg::sfrt_req_t req;

  logic [31:0]      pool_base_r;
  logic             res_valid;
  logic             res_ready;
  logic [OUT_W-1:0] res_data;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  // Unpack the request
  assign req.opcode        = in_tuser;
  assign req.space_id      = in_tdata[3:0];
  assign req.is_stack_page = in_tdata[4];
  assign req.page_number   = in_tdata[9:5];

  // Pool base register, always ready; the result reads it when it is built
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      pool_base_r <= cfg_data;
    end
  end

  sfrt_core #(
    .FRAME_COUNT(FRAME_COUNT),
    .FRAME_BYTES(FRAME_BYTES),
    .OUT_W      (OUT_W)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .pool_base(pool_base_r),
    .req_valid(in_tvalid),
    .req_ready(in_tready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  // Output register: load when empty or draining
  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

`ifndef NO_ASSERTIONS
  // A request in progress blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in the table");

  // Handing a result to the output register frees the table
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> in_tready)
    else $error("table not idle after its result was transferred");

  // An eviction comes only from an allocate, which frees nothing
  a_evict_no_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[EV_BIT]) |-> (out_tdata[FREED_LO +: CNT_W] == '0))
    else $error("eviction reported together with a freed count");
`endif

endmodule
